/* hw/rtl/escal_pkg.sv */
package escal_pkg;

  localparam int unsigned SecsWidth = 32;
  localparam int unsigned TodWidth = 17;
  localparam int unsigned DaysWidth = 16;
  localparam int unsigned CntWidth = 1;

  localparam logic [TodWidth-1:0] SecsPerDay = 17'd86400;
  localparam logic [TodWidth-1:0] SecsPerHour = 17'd3600;
  localparam logic [TodWidth-1:0] SecsPerMin = 17'd60;

  // Reciprocals for exact division after the power-of-two factor is shifted out:
  // days = ((secs >> 7) * DayRecip) >> 35, hour = ((tod >> 4) * HourRecip) >> 21,
  // minute = ((rem >> 2) * MinRecip) >> 14.
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip = 11'd1093;

  localparam logic [11:0] EpochYear = 12'd1970;
  localparam logic [6:0] EpochMod100 = 7'd70;
  localparam logic [8:0] EpochMod400 = 9'd370;
  localparam logic [8:0] DaysCommonYear = 9'd365;
  localparam logic [8:0] DaysLeapYear = 9'd366;

  localparam logic [CntWidth-1:0] DivSteps = 1'd1;
  localparam logic [CntWidth-1:0] HourSteps = 1'd1;
  localparam logic [CntWidth-1:0] MinSteps = 1'd1;

  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonDec = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIV,
    OP_HOUR,
    OP_MIN,
    OP_YEAR,
    OP_MONTH
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic year_done;
    logic month_done;
    logic out_free;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/escal_ctrl.sv */
module escal_ctrl
  import escal_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{load: 1'b0, op: OP_NONE, out_load: 1'b0};
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (status.cnt_zero) begin
          state_next = ST_HOUR;
        end
      end
      ST_HOUR: begin
        cmd.op = OP_HOUR;
        if (status.cnt_zero) begin
          state_next = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd.op = OP_MIN;
        if (status.cnt_zero) begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd.op = OP_YEAR;
        if (status.year_done) begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.op = OP_MONTH;
        if (status.month_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/escal_datapath.sv */
module escal_datapath
  import escal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [SecsWidth-1:0] epoch_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [11:0]          year,
  output logic [3:0]           month,
  output logic [4:0]           day,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           second
);

  logic [SecsWidth-1:0] work;
  logic [TodWidth-1:0]  rem;
  logic [CntWidth-1:0]  cnt;
  logic [4:0]           hour_acc;
  logic [5:0]           min_acc;
  logic [11:0]          year_acc;
  logic [6:0]           mod100;
  logic [8:0]           mod400;
  logic [3:0]           mon;
  logic [DaysWidth-1:0] days;

  logic [50:0]          day_prod;
  logic [SecsWidth-1:0] day_secs;
  logic [SecsWidth-1:0] tod_full;
  logic [25:0]          hour_prod;
  logic [TodWidth-1:0]  hour_secs;
  logic [19:0]          min_prod;
  logic [TodWidth-1:0]  min_secs;
  logic                 leap;
  logic [8:0]           year_len;
  logic                 year_ge;
  logic [4:0]           mon_len;
  logic                 mon_ge;

  assign day_prod = {26'd0, work[SecsWidth-1:7]} * {25'd0, DayRecip};
  assign day_secs = {16'd0, days} * {15'd0, SecsPerDay};
  assign tod_full = work - day_secs;
  assign hour_prod = {13'd0, rem[TodWidth-1:4]} * {12'd0, HourRecip};
  assign hour_secs = {12'd0, hour_acc} * SecsPerHour;
  assign min_prod = {10'd0, rem[11:2]} * {9'd0, MinRecip};
  assign min_secs = {11'd0, min_acc} * SecsPerMin;
  assign leap = ((year_acc[1:0] == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign year_len = leap ? DaysLeapYear : DaysCommonYear;
  assign year_ge = days >= {7'd0, year_len};
  assign mon_len = month_len(mon, leap);
  assign mon_ge = days >= {11'd0, mon_len};

  assign status.cnt_zero = (cnt == '0);
  assign status.year_done = !year_ge;
  assign status.month_done = !mon_ge || (mon == MonDec);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= epoch_seconds;
      days <= '0;
      rem <= '0;
      cnt <= DivSteps;
      hour_acc <= '0;
      min_acc <= '0;
      year_acc <= EpochYear;
      mod100 <= EpochMod100;
      mod400 <= EpochMod400;
      mon <= '0;
    end else begin
      unique case (cmd.op)
        OP_DIV: begin
          if (cnt != '0) begin
            days <= day_prod[50:35];
            cnt <= cnt - 1'b1;
          end else begin
            rem <= tod_full[TodWidth-1:0];
            cnt <= HourSteps;
          end
        end
        OP_HOUR: begin
          if (cnt != '0) begin
            hour_acc <= hour_prod[25:21];
            cnt <= cnt - 1'b1;
          end else begin
            rem <= rem - hour_secs;
            cnt <= MinSteps;
          end
        end
        OP_MIN: begin
          if (cnt != '0) begin
            min_acc <= min_prod[19:14];
            cnt <= cnt - 1'b1;
          end else begin
            rem <= rem - min_secs;
          end
        end
        OP_YEAR: begin
          if (year_ge) begin
            days <= days - {7'd0, year_len};
            year_acc <= year_acc + 1'b1;
            mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 1'b1;
            mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 1'b1;
          end
        end
        OP_MONTH: begin
          if (mon_ge && (mon != MonDec)) begin
            days <= days - {11'd0, mon_len};
            mon <= mon + 1'b1;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      year <= year_acc;
      month <= mon + 1'b1;
      day <= days[4:0] + 1'b1;
      hour <= hour_acc;
      minute <= min_acc;
      second <= rem[5:0];
    end
  end

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date and the time of day.
// The input channel (in_valid, in_ready, epoch_seconds) takes one beat per
// conversion. The output channel (out_valid, out_ready and the six date and
// time fields) gives one beat per input beat, in order.
// A conversion runs through a sequencer: it splits the count into days and
// seconds of the day by reciprocal multiplication, then derives the hour and
// then the minute, walks the years from 1970 one at a time, walks the months
// one at a time, and finally loads the output register. in_ready is high
// only while the sequencer is idle, so the next beat can be taken in the
// cycle after the result is loaded; a new beat is never taken before the
// previous conversion has finished.
// The result sits in an output register; a new input is accepted while it
// waits. If the receiver still stalls when the next result is finished, the
// sequencer holds that result and does not take further input.
// Reset clears the sequencer and out_valid; any conversion in flight is lost.
module epoch_seconds_to_calendar
  import escal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SecsWidth-1:0] epoch_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [11:0]          year,
  output logic [3:0]           month,
  output logic [4:0]           day,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           second
);

  cmd_t    cmd;
  status_t status;

  escal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  escal_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule

/* hw/rtl/escal_checker.sv */
module escal_checker
  import escal_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a conversion was starting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(year) && $stable(month)
      && $stable(day) && $stable(hour) && $stable(minute) && $stable(second)))
    else $error("stalled output beat changed");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month != 4'd0 && month <= 4'd12 && day != 5'd0
      && year >= 12'd1970 && year <= 12'd2106))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar escal_checker u_escal_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .year      (year),
  .month     (month),
  .day       (day),
  .hour      (hour),
  .minute    (minute),
  .second    (second)
);

/* sim/epoch_seconds_to_calendar_tb.sv */
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;
  import escal_pkg::*;

  localparam int unsigned SecsPerDayTb = 86400;
  localparam int unsigned DirectedCount = 22;
  localparam int unsigned RandomCount = 1000;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned HoldOffAfter = 100;
  localparam int unsigned BurstStart = 30000;
  localparam int unsigned BurstEnd = 60000;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct packed {
    logic [SecsWidth-1:0] stamp;
    cal_t                 date;
  } dated_stamp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SecsWidth-1:0] epoch_seconds = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [11:0]          year;
  logic [3:0]           month;
  logic [4:0]           day;
  logic [4:0]           hour;
  logic [5:0]           minute;
  logic [5:0]           second;

  logic [SecsWidth-1:0] stamps_pending[$];
  dated_stamp_t         dates_due[$];

  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned stall_left = 0;
  bit          held_off = 1'b0;
  int unsigned year_lo = 4095;
  int unsigned year_hi = 0;
  logic        gaps_on;

  epoch_seconds_to_calendar DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    case (m)
      1:       return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic cal_t to_calendar(input logic [SecsWidth-1:0] secs);
    cal_t        r;
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    days = secs / SecsPerDayTb;
    tod = secs % SecsPerDayTb;
    yr = 1970;
    mon = 0;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days = days - (leap_year(yr) ? 366 : 365);
      yr++;
    end
    while (mon < 11 && days >= days_in_month(mon, leap_year(yr))) begin
      days = days - days_in_month(mon, leap_year(yr));
      mon++;
    end
    r.year = yr[11:0];
    r.month = 4'(mon + 1);
    r.day = 5'(days + 1);
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod % 3600) / 60);
    r.second = 6'(tod % 60);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [SecsWidth-1:0] stamp,
                             input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: stamp %0d %s expected %0d, actual %0d", $time, stamp, fname, want, got);
      n_errors++;
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  assign gaps_on = !(cycle_count >= BurstStart && cycle_count < BurstEnd);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        dates_due.push_back('{stamp: epoch_seconds, date: to_calendar(epoch_seconds)});
      end
      if (!in_valid || in_ready) begin
        if (stamps_pending.size() > 0 && !(gaps_on && $urandom_range(99) < 24)) begin
          in_valid <= 1'b1;
          epoch_seconds <= stamps_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off once, for a long stretch, after the first beats are checked.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (!held_off && n_checked >= HoldOffAfter) begin
      held_off <= 1'b1;
      stall_left <= HoldOffCycles;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    dated_stamp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (dates_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                   $time, year, month, day, hour, minute, second);
          n_errors++;
        end else begin
          want = dates_due.pop_front();
          check_field("year", want.stamp, want.date.year, year);
          check_field("month", want.stamp, want.date.month, month);
          check_field("day", want.stamp, want.date.day, day);
          check_field("hour", want.stamp, want.date.hour, hour);
          check_field("minute", want.stamp, want.date.minute, minute);
          check_field("second", want.stamp, want.date.second, second);
          n_checked++;
          if (want.date.year < year_lo) year_lo = want.date.year;
          if (want.date.year > year_hi) year_hi = want.date.year;
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 24);
      end
    end
  end

  initial begin
    logic [SecsWidth-1:0] directed[DirectedCount];
    longint               base_days;
    longint               t;
    int unsigned          y;
    int unsigned          m;
    int unsigned          k;
    int unsigned          pick;

    // Epoch, day and year edges, leap days under each leap rule, the top of the range.
    directed = '{32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
                 32'd68169600, 32'd68255999, 32'd68256000, 32'd94694399, 32'd94694400,
                 32'd951782400, 32'd951868799, 32'd978307199, 32'd978307200,
                 32'd4107542399, 32'd4107542400, 32'd4291747199, 32'd4291747200,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF};
    foreach (directed[i]) stamps_pending.push_back(directed[i]);

    for (int i = 0; i < RandomCount; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        stamps_pending.push_back($urandom());
      end else if (pick < 58) begin
        stamps_pending.push_back($urandom_range(200000));
      end else if (pick < 66) begin
        stamps_pending.push_back(32'hFFFF_FFFF - $urandom_range(200000));
      end else begin
        // Land within a day of the start of a random month.
        y = $urandom_range(2106, 1970);
        m = $urandom_range(11, 0);
        base_days = 0;
        for (k = 1970; k < y; k++) base_days += leap_year(k) ? 366 : 365;
        for (k = 0; k < m; k++) base_days += days_in_month(k, leap_year(y));
        t = base_days * SecsPerDayTb + longint'($urandom_range(2 * SecsPerDayTb))
            - longint'(SecsPerDayTb);
        if (t < 0 || t > 64'hFFFF_FFFF) begin
          stamps_pending.push_back($urandom());
        end else begin
          stamps_pending.push_back(t[31:0]);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (stamps_pending.size() != 0 || in_valid || dates_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted and checked %0d timestamps, including a %0d-cycle output stall,",
             n_checked, HoldOffCycles);
    $display("with calendar years from %0d through %0d.", year_lo, year_hi);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
